// ===== src/esc_pkg.sv =====
// Shared types and constants of the enhanced second-chance replacer.
`timescale 1ns / 1ps

package esc_pkg;

  localparam int COUNT_W    = 4;
  localparam int FRAME_W    = 3;
  localparam int PAGE_W     = 16;
  localparam int COUNT_MAX  = 15;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd8;

  typedef struct packed {
    logic capture;
    logic look;
    logic sweep;
    logic commit;
  } esc_cmd_t;

  typedef struct packed {
    logic resolved;
    logic found;
    logic out_free;
  } esc_status_t;

endpackage

// ===== src/esc_ctrl.sv =====
// Controller state machine of the replacer: lookup, clock sweep, commit.
`timescale 1ns / 1ps

module esc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  esc_pkg::esc_status_t status,
  output esc_pkg::esc_cmd_t    cmd
);
  import esc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LOOK  = 4'b0010,
    S_SWEEP = 4'b0100,
    S_WRITE = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    in_ready    = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look   = 1'b1;
        state_next = status.resolved ? S_WRITE : S_SWEEP;
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (status.found) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/esc_datapath.sv =====
// Datapath of the replacer: frame table, clock hand, tag compare, output register.
`timescale 1ns / 1ps

module esc_datapath #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [esc_pkg::PAGE_W-1:0]   page_number,
  input  logic                         write_access,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [esc_pkg::COUNT_W-1:0]  cfg_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         hit,
  output logic [esc_pkg::FRAME_W-1:0]  frame_index,
  input  esc_pkg::esc_cmd_t            cmd,
  output esc_pkg::esc_status_t         status
);
  import esc_pkg::*;

  // only frames below the largest programmable count are ever used
  localparam int NF = (FRAMES < COUNT_MAX) ? FRAMES : COUNT_MAX;
  localparam int IW = (NF > 1) ? $clog2(NF) : 1;
  localparam int TW = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
  localparam logic [COUNT_W-1:0] NF_C = COUNT_W'(NF);

  logic [TW-1:0]      tags [NF];
  logic [NF-1:0]      valid;
  logic [NF-1:0]      refb;
  logic [NF-1:0]      modb;
  logic [COUNT_W-1:0] count;
  logic [IW-1:0]      hand;
  logic [1:0]         pass;
  logic [COUNT_W-1:0] step;
  logic [IW-1:0]      slot;
  logic               was_hit;
  logic [TW-1:0]      in_page;
  logic               in_wr;

  logic [COUNT_W-1:0] fcount;
  logic               hit_any, empty_any;
  logic [IW-1:0]      hit_idx, empty_idx;
  logic [IW-1:0]      hand_inc, hand_inc2;
  logic               sweep_match, sweep_last, sweep_exhaust;
  logic [IW+FRAME_W-1:0] slot_ext;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] p,
                                             input logic [COUNT_W-1:0] f);
    logic [COUNT_W-1:0] n;
    n = COUNT_W'(p) + 1'b1;
    return (n >= f) ? '0 : IW'(n);
  endfunction

  assign cfg_ready = 1'b1;

  always_comb begin
    if (count == '0) begin
      fcount = COUNT_W'(1);
    end else if (count > NF_C) begin
      fcount = NF_C;
    end else begin
      fcount = count;
    end
  end

  always_comb begin
    hit_any   = 1'b0;
    hit_idx   = '0;
    empty_any = 1'b0;
    empty_idx = '0;
    for (int i = NF - 1; i >= 0; i--) begin
      if (COUNT_W'(i) < fcount) begin
        if (valid[i] && tags[i] == in_page) begin
          hit_any = 1'b1;
          hit_idx = IW'(i);
        end
        if (!valid[i]) begin
          empty_any = 1'b1;
          empty_idx = IW'(i);
        end
      end
    end
  end

  assign hand_inc      = wrap_inc(hand, fcount);
  assign hand_inc2     = wrap_inc(hand_inc, fcount);
  assign sweep_match   = !refb[hand] && (modb[hand] == pass[0]);
  assign sweep_last    = (step == fcount - 1'b1);
  assign sweep_exhaust = (pass == 2'd3) && sweep_last;

  assign status.resolved = hit_any || empty_any;
  assign status.found    = sweep_match || sweep_exhaust;
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_page <= page_number[TW-1:0];
      in_wr   <= write_access;
    end
    if (cmd.commit && !was_hit) begin
      tags[slot] <= in_page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      refb      <= '0;
      modb      <= '0;
      count     <= COUNT_RESET;
      hand      <= '0;
      pass      <= '0;
      step      <= '0;
      slot      <= '0;
      was_hit   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        count <= cfg_data;
      end
      if (cmd.look) begin
        was_hit <= hit_any;
        slot    <= hit_any ? hit_idx : empty_idx;
        pass    <= '0;
        step    <= '0;
        if (!hit_any && !empty_any && COUNT_W'(hand) >= fcount) begin
          hand <= '0;
        end
      end
      if (cmd.sweep) begin
        priority if (sweep_match) begin
          slot <= hand;
          hand <= hand_inc;
        end else if (sweep_exhaust) begin
          slot <= hand_inc;
          hand <= hand_inc2;
        end else begin
          if (pass == 2'd1) begin
            refb[hand] <= 1'b0;
          end
          hand <= hand_inc;
          if (sweep_last) begin
            step <= '0;
            pass <= pass + 1'b1;
          end else begin
            step <= step + 1'b1;
          end
        end
      end
      if (cmd.commit) begin
        valid[slot] <= 1'b1;
        refb[slot]  <= 1'b1;
        modb[slot]  <= in_wr;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign slot_ext = {{FRAME_W{1'b0}}, slot};

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit         <= was_hit;
      frame_index <= slot_ext[FRAME_W-1:0];
    end
  end

endmodule

// ===== src/enhanced_second_chance_replacer.sv =====
// Top level of the enhanced second-chance (clock) page replacer.
//
// Input channel (in_valid/in_ready) takes one word per page reference:
// page_number and write_access. Output channel (out_valid/out_ready) gives
// one word per reference: hit and frame_index. cfg_valid/cfg_ready writes
// frames_in_use (cfg_data); cfg_ready is always high, write only while idle.
// A hit or a fill into an empty frame goes from accept through the lookup
// state to the commit that loads out_valid. A replacement adds the clock
// hand sweep, which visits one frame per cycle, before the commit.
// One reference is in flight at a time, so a new reference is accepted
// only once the last one is committed; in_ready rises again together
// with out_valid, when the result is loaded into the output register.
// Reset clears valid, R and M bits and the hand, sets frames_in_use to 8;
// no clearing pass is needed. A stalled receiver holds the result in the
// output register; the next reference is still accepted and looked up, and
// waits to commit until the output register is free.
`timescale 1ns / 1ps

module enhanced_second_chance_replacer #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [esc_pkg::PAGE_W-1:0]   page_number,
  input  logic                         write_access,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         hit,
  output logic [esc_pkg::FRAME_W-1:0]  frame_index,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [esc_pkg::COUNT_W-1:0]  cfg_data
);
  import esc_pkg::*;

  esc_cmd_t    cmd;
  esc_status_t status;

  esc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  esc_datapath #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .page_number  (page_number),
    .write_access (write_access),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hit          (hit),
    .frame_index  (frame_index),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

// ===== tb/tb_enhanced_second_chance_replacer.sv =====
// Self-checking testbench for the enhanced second-chance page replacer.
`timescale 1ns / 1ps

module tb_enhanced_second_chance_replacer;

  import esc_pkg::*;

  localparam int NFRAMES = 8;

  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame;
  } lookup_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [PAGE_W-1:0]  page_number;
  logic               write_access;
  logic               out_valid;
  logic               out_ready;
  logic               hit;
  logic [FRAME_W-1:0] frame_index;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [COUNT_W-1:0] cfg_data;

  enhanced_second_chance_replacer #(
    .FRAMES    (NFRAMES),
    .PAGE_BITS (PAGE_W)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .page_number  (page_number),
    .write_access (write_access),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hit          (hit),
    .frame_index  (frame_index),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  // frame table mirror
  logic [PAGE_W-1:0]  frame_tag [NFRAMES];
  logic               frame_vld [NFRAMES];
  logic               frame_r   [NFRAMES];
  logic               frame_m   [NFRAMES];
  int                 hand_pos;
  logic [COUNT_W-1:0] frames_reg;

  lookup_t lookup_q[$];
  lookup_t got_want;
  int      errors;
  bit      tx_steady;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #15_000_000;
    $display("enhanced_second_chance_replacer regression: fail");
    $finish;
  end

  function automatic int active_frames();
    if (frames_reg == 0) return 1;
    if (frames_reg > NFRAMES) return NFRAMES;
    return int'(frames_reg);
  endfunction

  task automatic choose_victim(input int f, output int victim);
    int  p;
    bit  done;
    done = 1'b0;
    victim = 0;
    if (hand_pos >= f) hand_pos = 0;
    for (int pass = 0; pass < 4 && !done; pass++) begin
      for (int s = 0; s < f && !done; s++) begin
        p = hand_pos;
        hand_pos = (p + 1) % f;
        if (!frame_r[p] && (frame_m[p] == pass[0])) begin
          victim = p;
          done = 1'b1;
        end else if (pass == 1) begin
          frame_r[p] = 1'b0;
        end
      end
    end
    if (!done) begin
      victim = hand_pos;
      hand_pos = (victim + 1) % f;
    end
  endtask

  task automatic resolve_reference(input logic [PAGE_W-1:0] page, input logic wr,
                                   output lookup_t res);
    int f;
    int slot;
    bit found;
    bit empty;
    f = active_frames();
    slot = 0;
    found = 1'b0;
    empty = 1'b0;
    for (int i = 0; i < f && !found; i++) begin
      if (frame_vld[i] && frame_tag[i] == page) begin
        slot = i;
        found = 1'b1;
      end
    end
    if (found) begin
      frame_r[slot] = 1'b1;
      frame_m[slot] = wr;
    end else begin
      for (int i = 0; i < f && !empty; i++) begin
        if (!frame_vld[i]) begin
          slot = i;
          empty = 1'b1;
        end
      end
      if (!empty) choose_victim(f, slot);
      frame_tag[slot] = page;
      frame_vld[slot] = 1'b1;
      frame_r[slot]   = 1'b1;
      frame_m[slot]   = wr;
    end
    res.hit   = found;
    res.frame = slot[FRAME_W-1:0];
  endtask

  function automatic int tx_gap();
    int unsigned r;
    if (tx_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return int'($urandom_range(1, 3));
    if (r < 97) return int'($urandom_range(4, 10));
    return int'($urandom_range(20, 40));
  endfunction

  // call at a falling edge; returns at a falling edge
  task automatic send_ref(input logic [PAGE_W-1:0] page, input logic wr);
    lookup_t res;
    int      gap;
    in_valid     = 1'b1;
    page_number  = page;
    write_access = wr;
    do @(posedge clk); while (!in_ready);
    resolve_reference(page, wr, res);
    lookup_q.push_back(res);
    @(negedge clk);
    gap = tx_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (lookup_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_frames(input logic [COUNT_W-1:0] n);
    drain_results();
    cfg_valid = 1'b1;
    cfg_data  = n;
    do @(posedge clk); while (!cfg_ready);
    frames_reg = n;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // receiver: steady stretches, random stalls, rare long stalls
  initial begin : rx_side
    int unsigned run;
    bit          steady;
    out_ready = 1'b0;
    forever begin
      steady = ($urandom_range(0, 3) == 0);
      run = $urandom_range(20, 200);
      repeat (run) begin
        @(negedge clk);
        out_ready = steady ? 1'b1 : ($urandom_range(0, 99) < 70);
      end
      if ($urandom_range(0, 5) == 0) begin
        @(negedge clk);
        out_ready = 1'b0;
        repeat ($urandom_range(30, 60)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (lookup_q.size() == 0) begin
        errors++;
        $display("%0t: result word with none pending: hit=%0b frame=%0d",
                 $time, hit, frame_index);
      end else begin
        got_want = lookup_q.pop_front();
        if (hit !== got_want.hit) begin
          errors++;
          $display("%0t: hit mismatch: expected %0b actual %0b",
                   $time, got_want.hit, hit);
        end
        if (frame_index !== got_want.frame) begin
          errors++;
          $display("%0t: frame_index mismatch: expected %0d actual %0d",
                   $time, got_want.frame, frame_index);
        end
      end
    end
  end

  task automatic test_fill_and_hit();
    send_ref(16'h0000, 1'b0);
    send_ref(16'hFFFF, 1'b1);
    send_ref(16'hFFFF, 1'b0);
    send_ref(16'h0000, 1'b1);
  endtask

  // three frames: second sweep pass takes an (R,M)=(0,1) frame
  task automatic test_sweep_passes();
    write_frames(4'd3);
    send_ref(16'h1234, 1'b1);
    send_ref(16'hAAAA, 1'b0);
    send_ref(16'h5555, 1'b1);
  endtask

  task automatic test_count_limits();
    write_frames(4'd0);
    send_ref(16'h0F0F, 1'b0);
    send_ref(16'h0F0F, 1'b1);
    write_frames(4'd15);
    send_ref(16'hF0F0, 1'b0);
  endtask

  // frames beyond a shrunk count keep their pages; hand restarts; duplicate tags
  task automatic test_shrink_grow();
    logic [PAGE_W-1:0] parked;
    int                n;
    write_frames(4'd8);
    for (int i = 4; i < NFRAMES; i++) send_ref(PAGE_W'(16'h2200 + i), i[0]);
    n = 0;
    while (hand_pos < 4 && n < 8) begin
      send_ref(PAGE_W'(16'h7000 + n), n[0]);
      n++;
    end
    parked = frame_tag[5];
    write_frames(4'd2);
    send_ref(16'h3C3C, 1'b1);
    send_ref(parked, 1'b0);
    write_frames(4'd8);
    send_ref(parked, 1'b1);
    send_ref(frame_tag[6], 1'b0);
  endtask

  task automatic test_random_traffic();
    logic [COUNT_W-1:0] plan [12];
    logic [PAGE_W-1:0]  pool [12];
    int                 npool;
    int unsigned        r;
    logic [PAGE_W-1:0]  page;
    plan = '{4'd8, 4'd1, 4'd5, 4'd0, 4'd15, 4'd3, 4'd8, 4'd2, 4'd7, 4'd4, 4'd6, 4'd12};
    for (int ph = 0; ph < 12; ph++) begin
      write_frames(plan[ph]);
      tx_steady = ($urandom_range(0, 3) == 0);
      npool = active_frames() + int'($urandom_range(1, 4));
      for (int i = 0; i < npool; i++) pool[i] = PAGE_W'($urandom_range(0, 16'hFFFF));
      for (int k = 0; k < 150; k++) begin
        r = $urandom_range(0, 99);
        if (r < 80) page = pool[$urandom_range(0, npool - 1)];
        else if (r < 83) page = 16'h0000;
        else if (r < 86) page = 16'hFFFF;
        else page = PAGE_W'($urandom_range(0, 16'hFFFF));
        send_ref(page, 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 49) == 0) drain_results();
        if ($urandom_range(0, 59) == 0) tx_steady = ~tx_steady;
      end
    end
    tx_steady = 1'b0;
  endtask

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    page_number  = '0;
    write_access = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    errors       = 0;
    tx_steady    = 1'b0;
    hand_pos     = 0;
    frames_reg   = COUNT_RESET;
    for (int i = 0; i < NFRAMES; i++) begin
      frame_tag[i] = '0;
      frame_vld[i] = 1'b0;
      frame_r[i]   = 1'b0;
      frame_m[i]   = 1'b0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_fill_and_hit();
    test_sweep_passes();
    test_count_limits();
    test_shrink_grow();
    test_random_traffic();

    drain_results();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("enhanced_second_chance_replacer regression: pass");
    end else begin
      $display("enhanced_second_chance_replacer regression: fail");
    end
    $finish;
  end

endmodule

// ===== enhanced_second_chance_replacer.f =====
src/esc_pkg.sv
src/esc_ctrl.sv
src/esc_datapath.sv
src/enhanced_second_chance_replacer.sv
tb/tb_enhanced_second_chance_replacer.sv
